// ===== hdl/quadratic_surface_residual_macros.svh =====
// ----------------------------------------------------------------------------
// quadratic_surface_residual_macros.svh
// Assertion macros used by the checker file of the block.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_SURFACE_RESIDUAL_MACROS_SVH
`define QUADRATIC_SURFACE_RESIDUAL_MACROS_SVH

// Same-cycle implication, disabled during reset
`define QSR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qsr assertion failed");

// Next-cycle implication, disabled during reset
`define QSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qsr assertion failed");

`endif

// ===== hdl/qsr_pkg.sv =====
// ----------------------------------------------------------------------------
// qsr_pkg
// Types, constants and helper functions of the quadratic surface residual
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package qsr_pkg;

    // Statistics sizing
    localparam int MAX_POINTS  = 4096;
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int SUM_W       = 16 + $clog2(MAX_POINTS);

    // Square root unit
    localparam int SQ_W        = 36;
    localparam int ROOT_W      = 18;
    localparam int REM_W       = 22;
    localparam int SQRT_STEPS  = SQ_W / 2;

    // Sequencer counter wide enough for the longest iterative pass
    localparam int LONG_STEPS  = (SUM_W > SQRT_STEPS) ? SUM_W : SQRT_STEPS;
    localparam int STEP_W      = $clog2(LONG_STEPS + 1);

    // Coefficient table
    localparam int NUM_COEF    = 6;
    localparam int COEF_IDX_W  = 3;

    // Configuration port
    localparam int CFG_AW      = 5;
    localparam int CFG_DW      = 64;
    localparam int REG_W       = 48;

    // Request kinds
    localparam logic REQ_POINT = 1'b0;
    localparam logic REQ_COEF  = 1'b1;

    typedef enum logic [1:0] {
        REG_ORIGIN,
        REG_AXIS_U,
        REG_AXIS_V,
        REG_AXIS_W
    } t_reg;

    typedef struct packed {
        logic [REG_W-1:0] origin;
        logic [REG_W-1:0] axis_u;
        logic [REG_W-1:0] axis_v;
        logic [REG_W-1:0] axis_w;
    } t_cfg;

    // Datapath multiply/accumulate operations
    typedef enum logic [3:0] {
        OP_H,
        OP_Q,
        OP_U,
        OP_V,
        OP_UU,
        OP_UV,
        OP_VV,
        OP_C1,
        OP_C2,
        OP_C3,
        OP_C4,
        OP_C5,
        OP_E
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_APPLY,
        ST_SQI,
        ST_SQRT,
        ST_STAT,
        ST_DIVI,
        ST_DIV,
        ST_OUT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        t_op        op;
        logic [1:0] idx;
        logic       load;
        logic       wcoef;
        logic       mul;
        logic       apply;
        logic       sq_init;
        logic       sq_step;
        logic       stat;
        logic       div_init;
        logic       div_step;
        logic       push;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic last;
    } t_sts;

    // Component k of a packed x/y/z word
    function automatic logic signed [15:0] comp16(input logic [REG_W-1:0] v,
                                                  input logic [1:0] k);
        logic signed [15:0] r;
        case (k)
            2'd1:    r = v[31:16];
            2'd2:    r = v[47:32];
            default: r = v[15:0];
        endcase
        return r;
    endfunction

    // Saturate to signed 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [49:0] x);
        logic signed [15:0] r;
        if (x > 50'sd32767)
            r = 16'sh7FFF;
        else if (x < -50'sd32768)
            r = 16'sh8000;
        else
            r = x[15:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/qsr_cfg.sv =====
// ----------------------------------------------------------------------------
// qsr_cfg
// APB-style register file: frame origin and the three frame axes.
// ----------------------------------------------------------------------------
`default_nettype none

module qsr_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [qsr_pkg::CFG_AW-1:0]  paddr,
    input  wire logic [qsr_pkg::CFG_DW-1:0]  pwdata,
    output logic      [qsr_pkg::CFG_DW-1:0]  prdata,
    output logic                             pready,
    output qsr_pkg::t_cfg                    o_cfg
);
    import qsr_pkg::*;

    t_cfg r_cfg;
    t_reg sel;

    assign sel    = t_reg'(paddr[CFG_AW-1:3]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (sel)
                REG_ORIGIN: r_cfg.origin <= pwdata[REG_W-1:0];
                REG_AXIS_U: r_cfg.axis_u <= pwdata[REG_W-1:0];
                REG_AXIS_V: r_cfg.axis_v <= pwdata[REG_W-1:0];
                REG_AXIS_W: r_cfg.axis_w <= pwdata[REG_W-1:0];
            endcase
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        unique case (sel)
            REG_ORIGIN: prdata[REG_W-1:0] = r_cfg.origin;
            REG_AXIS_U: prdata[REG_W-1:0] = r_cfg.axis_u;
            REG_AXIS_V: prdata[REG_W-1:0] = r_cfg.axis_v;
            REG_AXIS_W: prdata[REG_W-1:0] = r_cfg.axis_w;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/qsr_ctrl.sv =====
// ----------------------------------------------------------------------------
// qsr_ctrl
// Sequencer: walks the datapath through the multiply program, the square
// root, the statistics update and, on a point marked last, the mean division, then hands off the item.
// ----------------------------------------------------------------------------
`default_nettype none

module qsr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_req_type,
    input  wire logic          i_out_ready,
    input  qsr_pkg::t_sts      i_sts,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output qsr_pkg::t_cmd      o_cmd
);
    import qsr_pkg::*;

    t_state              r_state, n_state;
    t_op                 r_op, n_op;
    logic [1:0]          r_idx, n_idx;
    logic [STEP_W-1:0]   r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    logic                last_idx;

    assign last_idx    = (r_idx == 2'd2);
    assign o_out_valid = r_out_valid;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_H;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.op    = r_op;
        o_cmd.idx   = r_idx;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_req_type == REQ_COEF) begin
                        o_cmd.wcoef = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_op       = OP_H;
                        n_idx      = '0;
                        n_state    = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_APPLY;
            end
            ST_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = ST_MUL;
                unique case (r_op)
                    OP_H, OP_Q, OP_U: begin
                        n_idx = last_idx ? 2'd0 : r_idx + 2'd1;
                        if (last_idx)
                            n_op = (r_op == OP_H) ? OP_Q : (r_op == OP_Q) ? OP_U : OP_V;
                    end
                    OP_V: begin
                        n_idx = last_idx ? 2'd0 : r_idx + 2'd1;
                        if (last_idx)
                            n_op = OP_UU;
                    end
                    OP_UU: n_op = OP_UV;
                    OP_UV: n_op = OP_VV;
                    OP_VV: begin
                        n_op  = OP_C1;
                        n_idx = '0;
                    end
                    OP_C1: n_op = OP_C2;
                    OP_C2: n_op = OP_C3;
                    OP_C3: n_op = OP_C4;
                    OP_C4: n_op = OP_C5;
                    OP_C5: n_op = OP_E;
                    OP_E: begin
                        if (last_idx) begin
                            n_state = ST_SQI;
                        end else begin
                            n_op  = OP_C1;
                            n_idx = r_idx + 2'd1;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_SQI: begin
                o_cmd.sq_init = 1'b1;
                n_cnt         = '0;
                n_state       = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.sq_step = 1'b1;
                n_cnt         = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(SQRT_STEPS - 1))
                    n_state = ST_STAT;
            end
            ST_STAT: begin
                o_cmd.stat = 1'b1;
                n_state    = i_sts.last ? ST_DIVI : ST_OUT;
            end
            ST_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == STEP_W'(SUM_W - 1))
                    n_state = ST_OUT;
            end
            ST_OUT: begin
                // Wait until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.push  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/qsr_dp.sv =====
// ----------------------------------------------------------------------------
// qsr_dp
// Datapath: coefficient table, one shared 24x32 signed multiplier with its
// accumulator, a bit-pair square root, the cloud statistics with a restoring
// divider for the mean, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qsr_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  qsr_pkg::t_cmd                        i_cmd,
    input  qsr_pkg::t_cfg                        i_cfg,
    output qsr_pkg::t_sts                        o_sts,
    input  wire logic signed [15:0]              i_comp_x,
    input  wire logic signed [15:0]              i_comp_y,
    input  wire logic signed [15:0]              i_comp_z,
    input  wire logic [qsr_pkg::COEF_IDX_W-1:0]  i_coef_index,
    input  wire logic                            i_last_point,
    output logic signed [15:0]                   o_surface_x,
    output logic signed [15:0]                   o_surface_y,
    output logic signed [15:0]                   o_surface_z,
    output logic [15:0]                          o_residual,
    output logic [15:0]                          o_max_residual,
    output logic [15:0]                          o_mean_residual,
    output logic                                 o_stats_valid
);
    import qsr_pkg::*;

    // Coefficient table and per-item operands
    logic [REG_W-1:0]       r_coef [NUM_COEF];
    logic signed [15:0]     r_p [3];
    logic signed [16:0]     r_d [3];
    logic                   r_last;

    // Multiply/accumulate state
    logic signed [55:0]     r_prod;
    logic signed [49:0]     r_acc;
    logic signed [20:0]     r_h;
    logic signed [23:0]     r_q [3];
    logic signed [15:0]     r_u, r_v;
    logic signed [31:0]     r_uu, r_uv, r_vv;
    logic signed [15:0]     r_s [3];
    logic [SQ_W-1:0]        r_sq;

    // Square root
    logic [SQ_W-1:0]        r_sx;
    logic [REM_W-1:0]       r_rem;
    logic [ROOT_W-1:0]      r_root;
    logic [15:0]            r_res;

    // Statistics and divider
    logic [15:0]            r_max;
    logic [SUM_W-1:0]       r_sum;
    logic [CNT_W-1:0]       r_cnt;
    logic [SUM_W-1:0]       r_dq;
    logic [CNT_W-1:0]       r_dr;

    // Output register
    logic signed [15:0]     r_o_s [3];
    logic [15:0]            r_o_res, r_o_max, r_o_mean;
    logic                   r_o_stats;

    logic signed [23:0]     op_a;
    logic signed [31:0]     op_b;
    logic signed [55:0]     mul_p;
    logic signed [49:0]     prod50, acc_sum, rnd14, rnd16, qrnd, c0_term, prod_sh8;
    logic signed [15:0]     cidx;
    logic signed [16:0]     e_val;
    logic [REM_W-1:0]       rem_sh, trial;
    logic                   sq_ge;
    logic [15:0]            res16;
    logic [CNT_W:0]         dt, dsub;
    logic                   dge;

    assign o_sts.last = r_last;

    // Operand select for the shared multiplier
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (i_cmd.op)
            OP_H: begin
                op_a = 24'(r_d[i_cmd.idx]);
                op_b = 32'(comp16(i_cfg.axis_w, i_cmd.idx));
            end
            OP_Q: begin
                op_a = 24'(r_h);
                op_b = 32'(comp16(i_cfg.axis_w, i_cmd.idx));
            end
            OP_U: begin
                op_a = r_q[i_cmd.idx];
                op_b = 32'(comp16(i_cfg.axis_u, i_cmd.idx));
            end
            OP_V: begin
                op_a = r_q[i_cmd.idx];
                op_b = 32'(comp16(i_cfg.axis_v, i_cmd.idx));
            end
            OP_UU: begin
                op_a = 24'(r_u);
                op_b = 32'(r_u);
            end
            OP_UV: begin
                op_a = 24'(r_u);
                op_b = 32'(r_v);
            end
            OP_VV: begin
                op_a = 24'(r_v);
                op_b = 32'(r_v);
            end
            OP_C1: begin
                op_a = 24'(comp16(r_coef[1], i_cmd.idx));
                op_b = 32'(r_u);
            end
            OP_C2: begin
                op_a = 24'(comp16(r_coef[2], i_cmd.idx));
                op_b = 32'(r_v);
            end
            OP_C3: begin
                op_a = 24'(comp16(r_coef[3], i_cmd.idx));
                op_b = r_uu;
            end
            OP_C4: begin
                op_a = 24'(comp16(r_coef[4], i_cmd.idx));
                op_b = r_uv;
            end
            OP_C5: begin
                op_a = 24'(comp16(r_coef[5], i_cmd.idx));
                op_b = r_vv;
            end
            OP_E: begin
                op_a = 24'(e_val);
                op_b = 32'(e_val);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign mul_p    = op_a * op_b;
    assign prod50   = r_prod[49:0];
    assign acc_sum  = r_acc + prod50;
    assign rnd14    = (acc_sum + 50'sd8192) >>> 14;
    assign rnd16    = (acc_sum + 50'sd32768) >>> 16;
    assign qrnd     = (prod50 + 50'sd8192) >>> 14;
    assign cidx     = comp16(r_coef[0], i_cmd.idx);
    assign c0_term  = 50'(cidx) <<< 16;
    assign prod_sh8 = prod50 <<< 8;
    assign e_val    = 17'(r_s[i_cmd.idx]) - 17'(r_p[i_cmd.idx]);

    // Square root step: bring down two bits, try root*4+1
    assign rem_sh = {r_rem[REM_W-3:0], r_sx[SQ_W-1 -: 2]};
    assign trial  = {{(REM_W-ROOT_W-2){1'b0}}, r_root, 2'b01};
    assign sq_ge  = (rem_sh >= trial);
    assign res16  = (|r_root[ROOT_W-1:16]) ? 16'hFFFF : r_root[15:0];

    // Divider step: shift in one dividend bit, subtract the count if it fits
    assign dt   = {r_dr, r_dq[SUM_W-1]};
    assign dge  = (dt >= {1'b0, r_cnt});
    assign dsub = dt - {1'b0, r_cnt};

    // Coefficient table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COEF; k++)
                r_coef[k] <= '0;
        end else if (i_cmd.wcoef && (i_coef_index < COEF_IDX_W'(NUM_COEF))) begin
            r_coef[i_coef_index] <= {i_comp_z, i_comp_y, i_comp_x};
        end
    end

    // Point load, multiply and accumulate
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_p[0] <= i_comp_x;
            r_p[1] <= i_comp_y;
            r_p[2] <= i_comp_z;
            r_d[0] <= 17'(i_comp_x) - 17'(comp16(i_cfg.origin, 2'd0));
            r_d[1] <= 17'(i_comp_y) - 17'(comp16(i_cfg.origin, 2'd1));
            r_d[2] <= 17'(i_comp_z) - 17'(comp16(i_cfg.origin, 2'd2));
            r_last <= i_last_point;
        end
        if (i_cmd.mul)
            r_prod <= mul_p;
        if (i_cmd.apply) begin
            unique case (i_cmd.op)
                OP_H, OP_U, OP_V: begin
                    r_acc <= (i_cmd.idx == 2'd0) ? prod50 : acc_sum;
                    if (i_cmd.idx == 2'd2) begin
                        if (i_cmd.op == OP_H)
                            r_h <= rnd14[20:0];
                        else if (i_cmd.op == OP_U)
                            r_u <= sat16(rnd14);
                        else
                            r_v <= sat16(rnd14);
                    end
                end
                OP_Q:  r_q[i_cmd.idx] <= 24'(r_d[i_cmd.idx]) - qrnd[23:0];
                OP_UU: r_uu <= r_prod[31:0];
                OP_UV: r_uv <= r_prod[31:0];
                OP_VV: r_vv <= r_prod[31:0];
                OP_C1: r_acc <= c0_term + prod_sh8;
                OP_C2: r_acc <= r_acc + prod_sh8;
                OP_C3, OP_C4: r_acc <= acc_sum;
                OP_C5: r_s[i_cmd.idx] <= sat16(rnd16);
                OP_E:  r_sq <= ((i_cmd.idx == 2'd0) ? '0 : r_sq) + r_prod[SQ_W-1:0];
                default: r_acc <= r_acc;
            endcase
        end
    end

    // Square root
    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_init) begin
            r_sx   <= r_sq;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.sq_step) begin
            r_sx   <= {r_sx[SQ_W-3:0], 2'b00};
            r_rem  <= sq_ge ? rem_sh - trial : rem_sh;
            r_root <= {r_root[ROOT_W-2:0], sq_ge};
        end
    end

    // Cloud statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= '0;
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.stat) begin
            if (r_cnt < CNT_W'(MAX_POINTS)) begin
                if (res16 > r_max)
                    r_max <= res16;
                r_sum <= r_sum + SUM_W'(res16);
                r_cnt <= r_cnt + 1'b1;
            end
        end else if (i_cmd.push && r_last) begin
            r_max <= '0;
            r_sum <= '0;
            r_cnt <= '0;
        end
    end

    // Residual latch and mean divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.stat)
            r_res <= res16;
        if (i_cmd.div_init) begin
            r_dq <= r_sum;
            r_dr <= '0;
        end else if (i_cmd.div_step) begin
            r_dq <= {r_dq[SUM_W-2:0], dge};
            r_dr <= dge ? dsub[CNT_W-1:0] : dt[CNT_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_o_s[0]  <= r_s[0];
            r_o_s[1]  <= r_s[1];
            r_o_s[2]  <= r_s[2];
            r_o_res   <= r_res;
            r_o_max   <= r_last ? r_max : 16'd0;
            r_o_mean  <= r_last ? r_dq[15:0] : 16'd0;
            r_o_stats <= r_last;
        end
    end

    assign o_surface_x     = r_o_s[0];
    assign o_surface_y     = r_o_s[1];
    assign o_surface_z     = r_o_s[2];
    assign o_residual      = r_o_res;
    assign o_max_residual  = r_o_max;
    assign o_mean_residual = r_o_mean;
    assign o_stats_valid   = r_o_stats;

endmodule

`default_nettype wire

// ===== hdl/quadratic_surface_residual.sv =====
// ----------------------------------------------------------------------------
// quadratic_surface_residual
// Projects a point onto a configured frame, evaluates a quadratic vector
// height field at the projected (u, v) and returns the surface point, the
// residual distance and, on the last point of a cloud, its max and mean.
// ----------------------------------------------------------------------------
// A coefficient write item is taken while idle and gives no result. A point
// item runs 33 multiplies on the one shared 24x32 multiplier (each a multiply
// state and an accumulate state), then the bit-pair square root, and on a
// point marked last the one bit per cycle mean divider, before its result is
// offered. One item is worked on at a time; the next item is accepted as soon
// as the result sits in the output register.
`default_nettype none

module quadratic_surface_residual (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [qsr_pkg::CFG_AW-1:0]      paddr,
    input  wire logic [qsr_pkg::CFG_DW-1:0]      pwdata,
    output logic      [qsr_pkg::CFG_DW-1:0]      prdata,
    output logic                                 pready,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic                            i_req_type,
    input  wire logic signed [15:0]              i_comp_x,
    input  wire logic signed [15:0]              i_comp_y,
    input  wire logic signed [15:0]              i_comp_z,
    input  wire logic [qsr_pkg::COEF_IDX_W-1:0]  i_coef_index,
    input  wire logic                            i_last_point,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic signed [15:0]                   o_surface_x,
    output logic signed [15:0]                   o_surface_y,
    output logic signed [15:0]                   o_surface_z,
    output logic [15:0]                          o_residual,
    output logic [15:0]                          o_max_residual,
    output logic [15:0]                          o_mean_residual,
    output logic                                 o_stats_valid
);
    import qsr_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    // Configuration registers
    qsr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer
    qsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // Arithmetic
    qsr_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg           (cfg),
        .o_sts           (sts),
        .i_comp_x        (i_comp_x),
        .i_comp_y        (i_comp_y),
        .i_comp_z        (i_comp_z),
        .i_coef_index    (i_coef_index),
        .i_last_point    (i_last_point),
        .o_surface_x     (o_surface_x),
        .o_surface_y     (o_surface_y),
        .o_surface_z     (o_surface_z),
        .o_residual      (o_residual),
        .o_max_residual  (o_max_residual),
        .o_mean_residual (o_mean_residual),
        .o_stats_valid   (o_stats_valid)
    );

endmodule

`default_nettype wire

// ===== hdl/qsr_chk.sv =====
// ----------------------------------------------------------------------------
// qsr_chk
// Port-level checker for the quadratic surface residual block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quadratic_surface_residual_macros.svh"

module qsr_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        i_req_type,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] o_max_residual,
    input wire logic [15:0] o_mean_residual,
    input wire logic        o_stats_valid
);
    import qsr_pkg::*;

    // A stalled item stays offered
    `QSR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // Statistics fields are zero on an ordinary point
    `QSR_ASSERT_NOW(a_stats_zero, i_clk, i_rst_n, o_out_valid && !o_stats_valid, o_max_residual == 16'd0 && o_mean_residual == 16'd0)

    // The mean never exceeds the maximum
    `QSR_ASSERT_NOW(a_mean_le_max, i_clk, i_rst_n, o_out_valid && o_stats_valid, o_mean_residual <= o_max_residual)

    // A point item keeps the block busy in the following cycle
    `QSR_ASSERT_NEXT(a_point_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_req_type == REQ_POINT), !o_in_ready)

endmodule

bind quadratic_surface_residual qsr_chk u_qsr_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_req_type      (i_req_type),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_max_residual  (o_max_residual),
    .o_mean_residual (o_mean_residual),
    .o_stats_valid   (o_stats_valid)
);

`default_nettype wire
